// ----- src/nfpa_pkg.sv -----
// shared types, constants and datapath command codes for the next-fit pool allocator
// no dependencies
package nfpa_pkg;

  localparam int POOL_UNITS = 4096;
  localparam int UNIT_BYTES = 16;
  localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
  localparam int IDX_W      = 13;
  localparam int ADDR_W     = 12;
  localparam int STEP_W     = 14;

  localparam logic [IDX_W-1:0]  SENT       = IDX_W'(POOL_UNITS);
  localparam logic [STEP_W-1:0] WALK_LIMIT = STEP_W'(2 * POOL_UNITS + 8);

  // datapath commands, also used as controller state codes
  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_START    = 5'd1;
  localparam logic [4:0] OP_A_RDROV  = 5'd2;
  localparam logic [4:0] OP_A_GETP   = 5'd3;
  localparam logic [4:0] OP_A_RDP    = 5'd4;
  localparam logic [4:0] OP_A_CHK    = 5'd5;
  localparam logic [4:0] OP_A_EXACT  = 5'd6;
  localparam logic [4:0] OP_A_SPLIT  = 5'd7;
  localparam logic [4:0] OP_A_SPLIT2 = 5'd8;
  localparam logic [4:0] OP_A_ADV    = 5'd9;
  localparam logic [4:0] OP_G_GROW   = 5'd10;
  localparam logic [4:0] OP_R_RDP    = 5'd11;
  localparam logic [4:0] OP_R_CHK    = 5'd12;
  localparam logic [4:0] OP_R_RDBP   = 5'd13;
  localparam logic [4:0] OP_R_GETBP  = 5'd14;
  localparam logic [4:0] OP_R_MRGN   = 5'd15;
  localparam logic [4:0] OP_R_LINKBP = 5'd16;
  localparam logic [4:0] OP_R_FINP   = 5'd17;
  localparam logic [4:0] OP_DONE     = 5'd18;

  typedef struct packed {
    logic [4:0] op;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic fit;
    logic exact;
    logic p_is_rover;
    logic a_limit;
    logic grow_ok;
    logic rel_found;
    logic rel_over;
    logic merge_n;
  } dp_stat_t;

endpackage

// ----- src/nfpa_datapath.sv -----
// datapath: header memory, list pointers, bump pointer and compare logic
// depends on nfpa_pkg
module nfpa_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nfpa_pkg::dp_cmd_t             cmd,
  input  logic [15:0]                   req_nbytes,
  input  logic [nfpa_pkg::ADDR_W-1:0]   req_block_addr,
  output nfpa_pkg::dp_stat_t            stat,
  output logic [nfpa_pkg::ADDR_W-1:0]   out_addr
);

  localparam int IW = nfpa_pkg::IDX_W;
  localparam int SW = nfpa_pkg::STEP_W;

  logic [2*IW-1:0] hdr_mem [nfpa_pkg::POOL_UNITS];
  logic [2*IW-1:0] rd_q;
  logic            rd_hi_r;
  logic [IW-1:0]   rd_idx;
  logic            we;
  logic [IW-1:0]   wr_idx;
  logic [2*IW-1:0] wr_data;

  logic [IW-1:0] rover_r, rover_nxt, sent_next_r, sent_next_nxt, bump_r, bump_nxt;
  logic [IW-1:0] nu_r, nu_nxt, bp_r, bp_nxt, p_r, p_nxt, n_r, n_nxt;
  logic [IW-1:0] prev_r, prev_nxt, size_prev_r, size_prev_nxt, size_p_r, size_p_nxt;
  logic [IW-1:0] lp_r, lp_nxt, size_bp_r, size_bp_nxt, link_bp_r, link_bp_nxt;
  logic [SW-1:0] asteps_r, asteps_nxt, rsteps_r, rsteps_nxt;
  logic [nfpa_pkg::ADDR_W-1:0] res_addr_r, res_addr_nxt, out_addr_r;

  logic [IW-1:0] d_next, d_size, nu_in, split_sz, split_p;
  logic [IW:0]   bp_end, p_end;

  // header read with sentinel substitution
  assign d_next = rd_hi_r ? sent_next_r : rd_q[2*IW-1:IW];
  assign d_size = rd_hi_r ? '0 : rd_q[IW-1:0];

  assign nu_in    = IW'((17'(req_nbytes) + 17'(nfpa_pkg::UNIT_BYTES - 1))
                        >> nfpa_pkg::UNIT_SHIFT) + IW'(1);
  assign split_sz = size_p_r - nu_r;
  assign split_p  = p_r + split_sz;
  assign bp_end   = {1'b0, bp_r} + {1'b0, d_size};
  assign p_end    = {1'b0, p_r} + {1'b0, size_p_r};

  // status to the controller
  always_comb begin
    stat.fit        = d_size >= nu_r;
    stat.exact      = d_size == nu_r;
    stat.p_is_rover = p_r == rover_r;
    stat.a_limit    = asteps_r >= nfpa_pkg::WALK_LIMIT;
    stat.grow_ok    = {1'b0, nu_r} <= ({1'b0, nfpa_pkg::SENT} - {1'b0, bump_r});
    stat.rel_found  = (bp_r > p_r && bp_r < d_next) ||
                      (p_r >= d_next && (bp_r > p_r || bp_r < d_next));
    stat.rel_over   = rsteps_r >= nfpa_pkg::WALK_LIMIT;
    stat.merge_n    = (n_r != nfpa_pkg::SENT) && (bp_end == {1'b0, n_r});
  end

  // command decode
  always_comb begin
    rover_nxt     = rover_r;
    sent_next_nxt = sent_next_r;
    bump_nxt      = bump_r;
    nu_nxt        = nu_r;
    bp_nxt        = bp_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    prev_nxt      = prev_r;
    size_prev_nxt = size_prev_r;
    size_p_nxt    = size_p_r;
    lp_nxt        = lp_r;
    size_bp_nxt   = size_bp_r;
    link_bp_nxt   = link_bp_r;
    asteps_nxt    = asteps_r;
    rsteps_nxt    = rsteps_r;
    res_addr_nxt  = res_addr_r;
    rd_idx        = p_r;
    we            = 1'b0;
    wr_idx        = p_r;
    wr_data       = {lp_r, size_p_r};
    case (cmd.op)
      nfpa_pkg::OP_START: begin
        nu_nxt       = nu_in;
        bp_nxt       = {1'b0, req_block_addr - nfpa_pkg::ADDR_W'(1)};
        p_nxt        = rover_r;
        asteps_nxt   = '0;
        rsteps_nxt   = '0;
        res_addr_nxt = '0;
      end
      nfpa_pkg::OP_A_RDROV: rd_idx = rover_r;
      nfpa_pkg::OP_A_GETP: begin
        prev_nxt      = rover_r;
        size_prev_nxt = d_size;
        p_nxt         = d_next;
      end
      nfpa_pkg::OP_A_RDP: rd_idx = p_r;
      nfpa_pkg::OP_A_CHK: begin
        size_p_nxt = d_size;
        lp_nxt     = d_next;
      end
      nfpa_pkg::OP_A_EXACT: begin
        // unlink the hole from its predecessor
        wr_idx  = prev_r;
        wr_data = {lp_r, size_prev_r};
        we      = !prev_r[IW-1];
        if (prev_r == nfpa_pkg::SENT) begin
          sent_next_nxt = lp_r;
        end
        rover_nxt    = prev_r;
        res_addr_nxt = nfpa_pkg::ADDR_W'(p_r + IW'(1));
      end
      nfpa_pkg::OP_A_SPLIT: begin
        // shrink the hole, block comes from its tail
        wr_idx    = p_r;
        wr_data   = {lp_r, split_sz};
        we        = !p_r[IW-1];
        p_nxt     = split_p;
        rd_idx    = split_p;
        rover_nxt = prev_r;
      end
      nfpa_pkg::OP_A_SPLIT2: begin
        wr_idx       = p_r;
        wr_data      = {d_next, nu_r};
        we           = !p_r[IW-1];
        res_addr_nxt = nfpa_pkg::ADDR_W'(p_r + IW'(1));
      end
      nfpa_pkg::OP_A_ADV: begin
        prev_nxt      = p_r;
        size_prev_nxt = size_p_r;
        p_nxt         = lp_r;
        asteps_nxt    = asteps_r + SW'(1);
      end
      nfpa_pkg::OP_G_GROW: begin
        // new region from the pool top, then released into the list
        wr_idx     = bump_r;
        wr_data    = {{IW{1'b0}}, nu_r};
        we         = 1'b1;
        bp_nxt     = bump_r;
        bump_nxt   = bump_r + nu_r;
        p_nxt      = rover_r;
        rsteps_nxt = '0;
        asteps_nxt = asteps_r + SW'(1);
      end
      nfpa_pkg::OP_R_RDP: rd_idx = p_r;
      nfpa_pkg::OP_R_CHK: begin
        n_nxt      = d_next;
        size_p_nxt = d_size;
        if (!stat.rel_found) begin
          p_nxt      = d_next;
          rsteps_nxt = rsteps_r + SW'(1);
        end
      end
      nfpa_pkg::OP_R_RDBP: rd_idx = bp_r;
      nfpa_pkg::OP_R_GETBP: begin
        size_bp_nxt = d_size;
        rd_idx      = n_r;
      end
      nfpa_pkg::OP_R_MRGN: begin
        wr_idx      = bp_r;
        wr_data     = {d_next, size_bp_r + d_size};
        we          = !bp_r[IW-1];
        link_bp_nxt = d_next;
        size_bp_nxt = size_bp_r + d_size;
      end
      nfpa_pkg::OP_R_LINKBP: begin
        wr_idx      = bp_r;
        wr_data     = {n_r, size_bp_r};
        we          = !bp_r[IW-1];
        link_bp_nxt = n_r;
      end
      nfpa_pkg::OP_R_FINP: begin
        // merge with the lower neighbour or link to it
        wr_idx    = p_r;
        we        = !p_r[IW-1];
        rover_nxt = p_r;
        if (p_r != nfpa_pkg::SENT && p_end == {1'b0, bp_r}) begin
          wr_data = {link_bp_r, size_p_r + size_bp_r};
        end else begin
          wr_data = {bp_r, size_p_r};
          if (p_r == nfpa_pkg::SENT) begin
            sent_next_nxt = bp_r;
          end
        end
      end
      default: ;
    endcase
  end

  // header memory
  always_ff @(posedge clk) begin
    if (we) begin
      hdr_mem[wr_idx[IW-2:0]] <= wr_data;
    end
    rd_q <= hdr_mem[rd_idx[IW-2:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rover_r     <= nfpa_pkg::SENT;
      sent_next_r <= nfpa_pkg::SENT;
      bump_r      <= '0;
    end else begin
      rover_r     <= rover_nxt;
      sent_next_r <= sent_next_nxt;
      bump_r      <= bump_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rd_hi_r     <= rd_idx[IW-1];
    nu_r        <= nu_nxt;
    bp_r        <= bp_nxt;
    p_r         <= p_nxt;
    n_r         <= n_nxt;
    prev_r      <= prev_nxt;
    size_prev_r <= size_prev_nxt;
    size_p_r    <= size_p_nxt;
    lp_r        <= lp_nxt;
    size_bp_r   <= size_bp_nxt;
    link_bp_r   <= link_bp_nxt;
    asteps_r    <= asteps_nxt;
    rsteps_r    <= rsteps_nxt;
    res_addr_r  <= res_addr_nxt;
    if (cmd.load_out) begin
      out_addr_r <= res_addr_r;
    end
  end

  assign out_addr = out_addr_r;

endmodule

// ----- src/nfpa_ctrl.sv -----
// controller: request sequencing for allocate, grow and free, plus result handshake
// depends on nfpa_pkg
module nfpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  input  nfpa_pkg::dp_stat_t stat,
  output nfpa_pkg::dp_cmd_t  cmd
);

  logic [4:0] state_r, state_nxt;
  logic       free_r, free_nxt;
  logic       ok_r, ok_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_ok_r, out_ok_nxt;
  logic       accept;
  logic [4:0] after_rel;

  assign in_stall  = state_r != nfpa_pkg::OP_NONE;
  assign accept    = in_valid && !in_stall;
  assign after_rel = free_r ? nfpa_pkg::OP_DONE : nfpa_pkg::OP_A_RDROV;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    free_nxt      = free_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    cmd.op        = state_r;
    cmd.load_out  = 1'b0;
    case (state_r)
      nfpa_pkg::OP_NONE: begin
        cmd.op = nfpa_pkg::OP_NONE;
        if (accept) begin
          cmd.op    = nfpa_pkg::OP_START;
          free_nxt  = in_cmd;
          ok_nxt    = in_cmd;
          state_nxt = in_cmd ? nfpa_pkg::OP_R_RDP : nfpa_pkg::OP_A_RDROV;
        end
      end
      nfpa_pkg::OP_A_RDROV: state_nxt = nfpa_pkg::OP_A_GETP;
      nfpa_pkg::OP_A_GETP:  state_nxt = nfpa_pkg::OP_A_RDP;
      nfpa_pkg::OP_A_RDP:   state_nxt = nfpa_pkg::OP_A_CHK;
      nfpa_pkg::OP_A_CHK: begin
        if (stat.a_limit) begin
          state_nxt = nfpa_pkg::OP_DONE;
        end else if (stat.fit) begin
          ok_nxt    = 1'b1;
          state_nxt = stat.exact ? nfpa_pkg::OP_A_EXACT : nfpa_pkg::OP_A_SPLIT;
        end else if (stat.p_is_rover) begin
          state_nxt = stat.grow_ok ? nfpa_pkg::OP_G_GROW : nfpa_pkg::OP_DONE;
        end else begin
          state_nxt = nfpa_pkg::OP_A_ADV;
        end
      end
      nfpa_pkg::OP_A_EXACT:  state_nxt = nfpa_pkg::OP_DONE;
      nfpa_pkg::OP_A_SPLIT:  state_nxt = nfpa_pkg::OP_A_SPLIT2;
      nfpa_pkg::OP_A_SPLIT2: state_nxt = nfpa_pkg::OP_DONE;
      nfpa_pkg::OP_A_ADV:    state_nxt = nfpa_pkg::OP_A_RDP;
      nfpa_pkg::OP_G_GROW:   state_nxt = nfpa_pkg::OP_R_RDP;
      nfpa_pkg::OP_R_RDP:    state_nxt = nfpa_pkg::OP_R_CHK;
      nfpa_pkg::OP_R_CHK: begin
        if (stat.rel_found) begin
          state_nxt = nfpa_pkg::OP_R_RDBP;
        end else if (stat.rel_over) begin
          state_nxt = after_rel;
        end else begin
          state_nxt = nfpa_pkg::OP_R_RDP;
        end
      end
      nfpa_pkg::OP_R_RDBP: state_nxt = nfpa_pkg::OP_R_GETBP;
      nfpa_pkg::OP_R_GETBP: begin
        state_nxt = stat.merge_n ? nfpa_pkg::OP_R_MRGN : nfpa_pkg::OP_R_LINKBP;
      end
      nfpa_pkg::OP_R_MRGN:   state_nxt = nfpa_pkg::OP_R_FINP;
      nfpa_pkg::OP_R_LINKBP: state_nxt = nfpa_pkg::OP_R_FINP;
      nfpa_pkg::OP_R_FINP:   state_nxt = after_rel;
      nfpa_pkg::OP_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          state_nxt     = nfpa_pkg::OP_NONE;
        end
      end
      default: state_nxt = nfpa_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfpa_pkg::OP_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    free_r   <= free_nxt;
    ok_r     <= ok_nxt;
    out_ok_r <= out_ok_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;

endmodule

// ----- src/next_fit_pool_allocator.sv -----
// top level of the next-fit pool allocator
// depends on nfpa_pkg, nfpa_ctrl and nfpa_datapath
//
// One request at a time. An allocate reads the rover and the first hole after it and tests
// that hole; an exact fit is unlinked with one header write, a split writes two headers. Every
// hole it passes over costs a header read, a test and an advance. Each time a lap fails, a region
// is cut from the pool top, if it has room, and inserted: the cut, a list walk that reads and
// tests each hole, the merge, and a restart of the search at the rover. A free walks the list
// from the rover up to and including the insertion point, then merges. The header memory does
// one read and one write a cycle with a registered read. The result sits in an output register,
// so the next request is taken while it waits; a done request holds there only while the
// previous result is still stalled.
module next_fit_pool_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_nbytes,
  input  logic [11:0] in_block_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_addr,
  output logic        out_ok
);

  nfpa_pkg::dp_cmd_t  dp_cmd;
  nfpa_pkg::dp_stat_t dp_stat;

  nfpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_ok    (out_ok),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  nfpa_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (dp_cmd),
    .req_nbytes     (in_nbytes),
    .req_block_addr (in_block_addr),
    .stat           (dp_stat),
    .out_addr       (out_addr)
  );

  // a failed allocate reports address zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_addr == 12'd0))
    else $error("failed allocate with nonzero address");

  // one request in flight: the cycle after a request the input is held off
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken back to back");

  // a result load always raises the output valid; loads come only from the done step
  assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load_out |=> out_valid)
    else $error("result load without valid");

endmodule

// ----- verif/nfpa_checker.sv -----
// request/result checker for the next-fit pool allocator: predicts every result and compares
// depends on nfpa_pkg for the pool geometry
`timescale 1ns / 1ps
module nfpa_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_nbytes,
  input  logic [11:0] in_block_addr,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [11:0] out_addr,
  input  logic        out_ok,
  output int          pending,
  output int          fail_count
);

  localparam int unsigned NUNITS = nfpa_pkg::POOL_UNITS;
  localparam int unsigned SENTINEL = nfpa_pkg::POOL_UNITS;
  localparam int unsigned STEP_MAX = 2 * nfpa_pkg::POOL_UNITS + 8;
  localparam int unsigned UBYTES = nfpa_pkg::UNIT_BYTES;

  typedef struct packed {
    logic [11:0] addr;
    logic        ok;
  } grant_t;

  // shadow copy of the header memory and list pointers
  int unsigned hole_next [NUNITS];
  int unsigned hole_size [NUNITS];
  int unsigned rover_idx;
  int unsigned head_next;
  int unsigned pool_top;
  bit          started;

  grant_t expected_grants[$];

  function automatic int unsigned next_of(int unsigned i);
    return (i < SENTINEL) ? hole_next[i] : head_next;
  endfunction

  function automatic int unsigned size_at(int unsigned i);
    return (i < SENTINEL) ? hole_size[i] : 0;
  endfunction

  function automatic void set_next(int unsigned i, int unsigned v);
    if (i < SENTINEL) hole_next[i] = v;
    else if (i == SENTINEL) head_next = v;
  endfunction

  function automatic void set_size(int unsigned i, int unsigned v);
    if (i < SENTINEL) hole_size[i] = v;
  endfunction

  // address-ordered insert with merge on both sides
  function automatic void insert_hole(int unsigned hdr);
    int unsigned p;
    int unsigned n;
    int unsigned steps;
    p = rover_idx;
    steps = 0;
    forever begin
      n = next_of(p);
      if (hdr > p && hdr < n) break;
      if (p >= n && (hdr > p || hdr < n)) break;
      steps++;
      if (steps > STEP_MAX) return;
      p = n;
    end
    n = next_of(p);
    if (n != SENTINEL && hdr + size_at(hdr) == n) begin
      set_size(hdr, size_at(hdr) + size_at(n));
      set_next(hdr, next_of(n));
    end else begin
      set_next(hdr, n);
    end
    if (p != SENTINEL && p + size_at(p) == hdr) begin
      set_size(p, size_at(p) + size_at(hdr));
      set_next(p, next_of(hdr));
    end else begin
      set_next(p, hdr);
    end
    rover_idx = p;
  endfunction

  // cut a region from the untouched pool top
  function automatic bit carve_top(int unsigned nu);
    int unsigned up;
    if (nu > SENTINEL - pool_top) return 0;
    up = pool_top;
    pool_top += nu;
    set_size(up, nu);
    insert_hole(up);
    return 1;
  endfunction

  function automatic grant_t predict_grant(logic cmd, logic [15:0] nbytes, logic [11:0] baddr);
    grant_t g;
    int unsigned nu;
    int unsigned prev;
    int unsigned p;
    int unsigned sz;
    g = '0;
    if (!started) begin
      started = 1;
      rover_idx = SENTINEL;
      head_next = SENTINEL;
    end
    if (cmd) begin
      insert_hole((baddr + SENTINEL - 1) % SENTINEL);
      g.ok = 1;
      return g;
    end
    nu = (nbytes + UBYTES - 1) / UBYTES + 1;
    prev = rover_idx;
    p = next_of(prev);
    for (int unsigned steps = 0; steps < STEP_MAX; steps++) begin
      sz = size_at(p);
      if (sz >= nu) begin
        if (sz == nu) begin
          set_next(prev, next_of(p));
        end else begin
          sz -= nu;
          set_size(p, sz);
          p += sz;
          set_size(p, nu);
        end
        rover_idx = prev;
        g.addr = 12'((p + 1) % SENTINEL);
        g.ok = 1;
        return g;
      end
      if (p == rover_idx) begin
        if (!carve_top(nu)) return g;
        p = rover_idx;
      end
      prev = p;
      p = next_of(p);
    end
    return g;
  endfunction

  task automatic report(string what, int exp_v, int got_v);
    $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
    fail_count++;
  endtask

  assign pending = expected_grants.size();

  // predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    grant_t e;
    if (!rst_n) begin
      for (int i = 0; i < NUNITS; i++) begin
        hole_next[i] = 0;
        hole_size[i] = 0;
      end
      rover_idx = SENTINEL;
      head_next = SENTINEL;
      pool_top = 0;
      started = 0;
      fail_count = 0;
      expected_grants.delete();
    end else begin
      if (in_valid && !in_stall)
        expected_grants.push_back(predict_grant(in_cmd, in_nbytes, in_block_addr));
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          report("results outstanding", 0, 1);
        end else begin
          e = expected_grants.pop_front();
          if (out_ok !== e.ok) report("ok", e.ok, out_ok);
          if (out_addr !== e.addr) report("addr", e.addr, out_addr);
        end
      end
    end
  end

endmodule

// ----- verif/testbench.sv -----
// top of the next-fit pool allocator testbench: clock, reset, request stimulus and verdict
// depends on next_fit_pool_allocator and nfpa_checker
`timescale 1ns / 1ps
module testbench;

  localparam int RANDOM_REQS = 1950;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd;
  logic [15:0] in_nbytes;
  logic [11:0] in_block_addr;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] out_addr;
  logic        out_ok;
  int          pending;
  int          fail_count;

  logic [11:0] live_blocks[$];
  logic        sent_cmds[$];
  int          n_alloc;
  int          n_free;
  int          n_exhausted = 0;
  int          stall_mode;

  next_fit_pool_allocator u_top (.*);

  nfpa_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("timeout");
    $display("TEST FAILED");
    $finish;
  end

  // receiver stall pattern: changes character now and then at random, among four modes
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ($urandom_range(0, 99) < 75);
        default: out_stall <= ($urandom_range(0, 7) == 0) ? ~out_stall : out_stall;
      endcase
    end
  end

  // track granted blocks so frees only name live ones
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sent_cmds.push_back(in_cmd);
      if (out_valid && !out_stall && sent_cmds.size() > 0) begin
        if (sent_cmds.pop_front() == 1'b0) begin
          if (out_ok) live_blocks.push_back(out_addr);
          else n_exhausted++;
        end
      end
    end
  end

  // one request; returns after the edge that accepts it, valid still high
  task automatic send_req(logic cmd, logic [15:0] nb, logic [11:0] ba);
    in_valid <= 1;
    in_cmd <= cmd;
    in_nbytes <= nb;
    in_block_addr <= ba;
    if (cmd) n_free++;
    else n_alloc++;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
  endtask

  task automatic go_idle(int cycles);
    in_valid <= 0;
    repeat (cycles) @(posedge clk);
  endtask

  // wait for every result, then for the block tracker to catch up
  task automatic drain();
    go_idle(1);
    while (pending != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic free_random();
    int k;
    logic [11:0] a;
    k = $urandom_range(0, live_blocks.size() - 1);
    a = live_blocks[k];
    live_blocks.delete(k);
    send_req(1, 16'($urandom), a);
  endtask

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 16'($urandom_range(0, 256));
    if (r < 95) return 16'($urandom_range(257, 4096));
    return 16'($urandom);
  endfunction

  initial begin
    logic [11:0] a;
    int burst;
    n_alloc = 0;
    n_free = 0;
    rst_n <= 0;
    in_valid <= 0;
    in_cmd <= 0;
    in_nbytes <= 0;
    in_block_addr <= 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // whole pool in one block, free it, take it again by exact fit
    send_req(0, 16'd65519, 12'h000);
    drain();
    a = live_blocks.pop_back();
    send_req(1, 16'hffff, a);
    send_req(0, 16'd65519, 12'hfff);
    send_req(0, 16'd65535, 12'h000);
    drain();
    a = live_blocks.pop_back();
    send_req(1, 16'h0000, a);

    // size edges including zero bytes and unit boundaries
    send_req(0, 16'd0, 12'h000);
    send_req(0, 16'd1, 12'h000);
    send_req(0, 16'd15, 12'h000);
    send_req(0, 16'd16, 12'h000);
    send_req(0, 16'd17, 12'h000);
    send_req(0, 16'd32, 12'h000);
    send_req(0, 16'd65535, 12'h000);
    drain();
    // free ends first, then the middle to merge both neighbours
    send_req(1, 16'h0, live_blocks[0]);
    send_req(1, 16'h0, live_blocks[2]);
    send_req(1, 16'h0, live_blocks[1]);
    send_req(1, 16'h0, live_blocks[4]);
    drain();
    live_blocks.delete(4);
    live_blocks.delete(2);
    live_blocks.delete(1);
    live_blocks.delete(0);

    // random traffic in bursts
    for (int i = 0; i < RANDOM_REQS; ) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst && i < RANDOM_REQS; j++, i++) begin
        if (live_blocks.size() > 0 && ($urandom_range(0, 99) < 45 || live_blocks.size() > 60))
          free_random();
        else
          send_req(0, pick_size(), 12'($urandom));
      end
      if (i == RANDOM_REQS / 2) drain();
      else if ($urandom_range(0, 3) == 0) go_idle($urandom_range(1, 12));
    end

    // release everything, then a double free to exercise the bounded walk
    drain();
    while (live_blocks.size() > 0) free_random();
    send_req(0, 16'd40, 12'h000);
    drain();
    a = live_blocks.pop_back();
    send_req(1, 16'h0, a);
    send_req(1, 16'h0, a);
    send_req(0, 16'd8, 12'h000);
    drain();
    repeat (100) @(posedge clk);

    $display("covered %0d allocate and %0d free requests, %0d allocates found the pool exhausted",
             n_alloc, n_free, n_exhausted);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- next_fit_pool_allocator.f -----
src/nfpa_pkg.sv
src/nfpa_datapath.sv
src/nfpa_ctrl.sv
src/next_fit_pool_allocator.sv
verif/nfpa_checker.sv
verif/testbench.sv
